@@ sv/beld_pkg.sv @@
// ----------------------------------------------------------------------------
// beld_pkg
// Types, opcodes and event codes shared by the button edge and long-hold
// detector.
// ----------------------------------------------------------------------------
package beld_pkg;

  localparam int PIN_W  = 5;
  localparam int CODE_W = 3;
  localparam int OP_W   = 2;
  localparam int HOLD_W = 24;
  localparam int LOCK_W = 16;
  localparam int IDX_W  = 3;
  localparam int ADDR_W = 2;

  typedef logic [PIN_W-1:0]  pins_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [HOLD_W-1:0] hold_t;
  typedef logic [LOCK_W-1:0] lock_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam op_t OP_TICK    = 2'd0;
  localparam op_t OP_SCAN    = 2'd1;
  localparam op_t OP_READ    = 2'd2;
  localparam op_t OP_RELEASE = 2'd3;

  localparam code_t CODE_CENTER_HOLD = 3'd5;
  localparam code_t CODE_RIGHT_HOLD  = 3'd6;

  localparam logic [ADDR_W-1:0] REG_HOLD_TICKS    = 2'd0;
  localparam logic [ADDR_W-1:0] REG_LOCKOUT_TICKS = 2'd1;
  localparam logic [ADDR_W-1:0] REG_CENTER_BIT    = 2'd2;
  localparam logic [ADDR_W-1:0] REG_RIGHT_BIT     = 2'd3;

  localparam hold_t HOLD_TICKS_RST    = 24'd10000;
  localparam lock_t LOCKOUT_TICKS_RST = 16'd300;
  localparam idx_t  CENTER_BIT_RST    = 3'd2;
  localparam idx_t  RIGHT_BIT_RST     = 3'd1;

  localparam pins_t PIN_MASK = 5'h1F;

  // an index past the last pin reads as released
  function automatic logic pin_is_low(input pins_t pins, input idx_t idx);
    logic low;
    low = 1'b0;
    if (idx < idx_t'(PIN_W)) begin
      low = ~pins[idx];
    end
    return low;
  endfunction

endpackage

@@ sv/button_edge_and_long_hold_detector.sv @@
// ----------------------------------------------------------------------------
// button_edge_and_long_hold_detector
// Press-edge and long-hold detector for five active-low buttons with a
// one-deep event slot, a post-press lockout and two long-hold timers.
//
//   port group | dir | tdata                  | tuser
//   in_        | in  | [4:0] pins             | [1:0] op
//   out_       | out | [2:0] event_code       | [0] event_valid
//   cfg_       | in  | wr_en, addr, wdata (no handshake, no read-back)
//
// One beat in, one beat out; each beat passes the input register, then the
// result register after the state update.
// A new beat is taken every cycle while the result register drains.
// A stalled output holds both stages; in_tready falls only then.
// rst_n is synchronous; all timers, flags and config return to defaults.
// ----------------------------------------------------------------------------
module button_edge_and_long_hold_detector #(
  parameter int NUM_BUTTONS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [4:0] pins
  input  logic [beld_pkg::OP_W-1:0]     in_tuser,   // [1:0] op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [2:0] event_code
  output logic [0:0]                    out_tuser,  // [0] event_valid
  input  logic                          cfg_wr_en,
  input  logic [beld_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [beld_pkg::HOLD_W-1:0]   cfg_wdata
);

  // config
  beld_pkg::hold_t hold_ticks_r;
  beld_pkg::lock_t lockout_ticks_r;
  beld_pkg::idx_t  center_bit_r;
  beld_pkg::idx_t  right_bit_r;

  // pipeline
  logic              in_vld_r;
  beld_pkg::op_t     in_op_r;
  beld_pkg::pins_t   in_pins_r;
  logic              out_vld_r;
  logic              out_evt_r;
  beld_pkg::code_t   out_code_r;
  logic              adv;

  // detector state
  beld_pkg::pins_t last_pins_r,   last_pins_nxt;
  logic            pend_r,        pend_nxt;
  beld_pkg::code_t pend_code_r,   pend_code_nxt;
  beld_pkg::lock_t lock_left_r,   lock_left_nxt;
  logic            lock_run_r,    lock_run_nxt;
  beld_pkg::hold_t c_left_r,      c_left_nxt;
  logic            c_run_r,       c_run_nxt;
  logic            c_seen_r,      c_seen_nxt;
  beld_pkg::hold_t r_left_r,      r_left_nxt;
  logic            r_run_r,       r_run_nxt;
  logic            r_seen_r,      r_seen_nxt;
  logic            evt_nxt;
  beld_pkg::code_t code_nxt;

  beld_pkg::pins_t btn_mask;

  always_comb begin
    btn_mask = '0;
    for (int i = 0; i < beld_pkg::PIN_W; i++) begin
      if (i < NUM_BUTTONS) begin
        btn_mask[i] = 1'b1;
      end
    end
  end

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r    <= beld_pkg::HOLD_TICKS_RST;
      lockout_ticks_r <= beld_pkg::LOCKOUT_TICKS_RST;
      center_bit_r    <= beld_pkg::CENTER_BIT_RST;
      right_bit_r     <= beld_pkg::RIGHT_BIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        beld_pkg::REG_HOLD_TICKS:    hold_ticks_r    <= cfg_wdata;
        beld_pkg::REG_LOCKOUT_TICKS: lockout_ticks_r <= cfg_wdata[beld_pkg::LOCK_W-1:0];
        beld_pkg::REG_CENTER_BIT:    center_bit_r    <= cfg_wdata[beld_pkg::IDX_W-1:0];
        beld_pkg::REG_RIGHT_BIT:     right_bit_r     <= cfg_wdata[beld_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic            blocked;
    logic            c_low;
    logic            r_low;
    logic            done;
    beld_pkg::pins_t falling;
    logic            hit;
    beld_pkg::code_t hit_code;

    last_pins_nxt = last_pins_r;
    pend_nxt      = pend_r;
    pend_code_nxt = pend_code_r;
    lock_left_nxt = lock_left_r;
    lock_run_nxt  = lock_run_r;
    c_left_nxt    = c_left_r;
    c_run_nxt     = c_run_r;
    c_seen_nxt    = c_seen_r;
    r_left_nxt    = r_left_r;
    r_run_nxt     = r_run_r;
    r_seen_nxt    = r_seen_r;
    evt_nxt       = 1'b0;
    code_nxt      = '0;
    blocked       = pend_r || (lock_run_r && (lock_left_r != '0));
    c_low         = beld_pkg::pin_is_low(in_pins_r, center_bit_r);
    r_low         = beld_pkg::pin_is_low(in_pins_r, right_bit_r);
    done          = 1'b0;
    falling       = ~in_pins_r & last_pins_r & btn_mask;
    hit           = 1'b0;
    hit_code      = '0;

    for (int i = beld_pkg::PIN_W - 1; i >= 0; i--) begin
      if (falling[i]) begin
        hit      = 1'b1;
        hit_code = beld_pkg::code_t'(i);
      end
    end

    case (in_op_r)
      beld_pkg::OP_TICK: begin
        if (lock_run_r && (lock_left_r != '0)) begin
          lock_left_nxt = lock_left_r - 16'd1;
        end
        if (c_run_r && (c_left_r != '0)) begin
          c_left_nxt = c_left_r - 24'd1;
        end
        if (r_run_r && (r_left_r != '0)) begin
          r_left_nxt = r_left_r - 24'd1;
        end
      end
      beld_pkg::OP_SCAN: begin
        if (!blocked) begin
          lock_run_nxt  = 1'b0;
          lock_left_nxt = '0;
          // center long hold
          if (c_low) begin
            if (!c_seen_r) begin
              c_run_nxt  = 1'b1;
              c_left_nxt = hold_ticks_r;
              c_seen_nxt = 1'b1;
            end
          end else begin
            c_run_nxt  = 1'b0;
            c_left_nxt = '0;
            c_seen_nxt = 1'b0;
          end
          if (c_run_nxt && (c_left_nxt == '0)) begin
            c_run_nxt     = 1'b0;
            pend_nxt      = 1'b1;
            pend_code_nxt = beld_pkg::CODE_CENTER_HOLD;
            done          = 1'b1;
          end
          // right long hold
          if (!done) begin
            if (r_low) begin
              if (!r_seen_r) begin
                r_run_nxt  = 1'b1;
                r_left_nxt = hold_ticks_r;
                r_seen_nxt = 1'b1;
              end
            end else begin
              r_run_nxt  = 1'b0;
              r_left_nxt = '0;
              r_seen_nxt = 1'b0;
            end
            if (r_run_nxt && (r_left_nxt == '0)) begin
              r_run_nxt     = 1'b0;
              pend_nxt      = 1'b1;
              pend_code_nxt = beld_pkg::CODE_RIGHT_HOLD;
              done          = 1'b1;
            end
          end
          // press edge, lowest button wins
          if (!done) begin
            if (hit) begin
              pend_nxt      = 1'b1;
              pend_code_nxt = hit_code;
              lock_run_nxt  = 1'b1;
              lock_left_nxt = lockout_ticks_r;
            end
            last_pins_nxt = in_pins_r;
          end
        end
      end
      beld_pkg::OP_READ: begin
        if (pend_r) begin
          evt_nxt  = 1'b1;
          code_nxt = pend_code_r;
          pend_nxt = 1'b0;
        end
      end
      default: begin
        last_pins_nxt = beld_pkg::PIN_MASK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      last_pins_r <= '0;
      pend_r      <= 1'b0;
      pend_code_r <= '0;
      lock_left_r <= '0;
      lock_run_r  <= 1'b0;
      c_left_r    <= '0;
      c_run_r     <= 1'b0;
      c_seen_r    <= 1'b0;
      r_left_r    <= '0;
      r_run_r     <= 1'b0;
      r_seen_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r   <= 1'b1;
        last_pins_r <= last_pins_nxt;
        pend_r      <= pend_nxt;
        pend_code_r <= pend_code_nxt;
        lock_left_r <= lock_left_nxt;
        lock_run_r  <= lock_run_nxt;
        c_left_r    <= c_left_nxt;
        c_run_r     <= c_run_nxt;
        c_seen_r    <= c_seen_nxt;
        r_left_r    <= r_left_nxt;
        r_run_r     <= r_run_nxt;
        r_seen_r    <= r_seen_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= in_tuser;
      in_pins_r <= in_tdata[beld_pkg::PIN_W-1:0];
    end
    if (adv) begin
      out_evt_r  <= evt_nxt;
      out_code_r <= code_nxt;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {{(8 - beld_pkg::CODE_W){1'b0}}, out_code_r};
  assign out_tuser[0] = out_evt_r;

`ifndef ASSERT_OFF
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[2:0] != 3'd7)
    else $error("event code out of range");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 8'd0)
    else $error("code not zero without event");

  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(pend_r) |-> !$past(rst_n) || $past(adv && in_op_r == beld_pkg::OP_READ))
    else $error("pending event dropped without read");

  a_lock_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(lock_run_r) |-> pend_r && pend_code_r < beld_pkg::CODE_CENTER_HOLD)
    else $error("lockout started without press event");
`endif

endmodule
